@@ hw/rtl/psqrt_pkg.sv @@
// Shared constants and controller-to-datapath command type for the square root block.
package psqrt_pkg;

   // Default operand width, in bits, including the sign bit.
   localparam int OPERAND_WIDTH_DEFAULT = 32;

   // Fixed widths of the stream payload fields.
   localparam int VALUE_WIDTH = 32;
   localparam int ROOT_WIDTH  = 16;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // Capture a new operand and start the root.
      logic step;    // Settle one root bit.
      logic finish;  // Check the remainder and write the result register.
   } psqrt_cmd_type;

endpackage

@@ hw/rtl/psqrt_datapath.sv @@
// Datapath of the square root block: digit-by-digit root iteration and result register.
module psqrt_datapath #(
   parameter int OPERAND_WIDTH = psqrt_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  psqrt_pkg::psqrt_cmd_type         cmd,
   input  logic [psqrt_pkg::VALUE_WIDTH-1:0] value,
   output logic [psqrt_pkg::ROOT_WIDTH-1:0]  root
);
   import psqrt_pkg::*;

   localparam int ITERS = OPERAND_WIDTH / 2;
   localparam logic [OPERAND_WIDTH-1:0] BIT_INIT =
      {{(OPERAND_WIDTH-1){1'b0}}, 1'b1} << (2 * (ITERS - 1));

   logic [OPERAND_WIDTH-1:0] rem_ff, rem_in;
   logic [OPERAND_WIDTH-1:0] res_ff, res_in;
   logic [OPERAND_WIDTH-1:0] bit_ff, bit_in;
   logic                     pos_ff, pos_in;
   logic [ROOT_WIDTH-1:0]    root_ff, root_in;

   logic [63:0]              value_ext;
   logic [63:0]              res_ext;
   logic [OPERAND_WIDTH-1:0] operand;
   logic [OPERAND_WIDTH:0]   trial;

   // Operand as a two's complement number of the configured width.
   assign value_ext = {{(64 - VALUE_WIDTH){value[VALUE_WIDTH-1]}}, value};
   assign operand   = value_ext[OPERAND_WIDTH-1:0];

   // Trial subtrahend of the current iteration.
   assign trial   = {1'b0, res_ff} + {1'b0, bit_ff};
   assign res_ext = 64'(res_ff);

   // Next values of the iteration registers and the result register.
   always_comb begin
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      pos_in  = pos_ff;
      root_in = root_ff;
      if (cmd.load) begin
         rem_in = operand;
         res_in = '0;
         bit_in = BIT_INIT;
         pos_in = !operand[OPERAND_WIDTH-1] && (operand != '0);
      end else if (cmd.step) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_in = rem_ff - trial[OPERAND_WIDTH-1:0];
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end
      if (cmd.finish) begin
         root_in = (pos_ff && (rem_ff == '0)) ? res_ext[ROOT_WIDTH-1:0] : '0;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      pos_ff  <= pos_in;
      root_ff <= root_in;
   end

   assign root = root_ff;

endmodule

@@ hw/rtl/psqrt_controller.sv @@
// Controller of the square root block: handshakes, iteration count and result valid.
module psqrt_controller #(
   parameter int OPERAND_WIDTH = psqrt_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output psqrt_pkg::psqrt_cmd_type cmd
);
   import psqrt_pkg::*;

   localparam int ITERS     = OPERAND_WIDTH / 2;
   localparam int CNT_WIDTH = (ITERS > 1) ? $clog2(ITERS) : 1;
   localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(ITERS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 out_free;
   logic                 accept;

   // The result register can take a new value when empty or being drained.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) || ((state_ff == ST_DONE) && out_free);
   assign accept     = req_tvalid && req_tready;

   assign cmd.load   = accept;
   assign cmd.step   = (state_ff == ST_RUN);
   assign cmd.finish = (state_ff == ST_DONE) && out_free;

   // Next state, iteration count and result valid flag.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               cnt_in   = '0;
            end
         end
         ST_RUN: begin
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               if (accept) begin
                  state_in = ST_RUN;
                  cnt_in   = '0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;

endmodule

@@ hw/rtl/perfect_square_root.sv @@
// Top level of the exact square root block with perfect-square test.
//
//   Channel   Direction  Payload                         Accepted when
//   req_      in         tdata[31:0] = value (signed)     req_tvalid && req_tready
//   rsp_      out        tdata[15:0] = root (unsigned)    rsp_tvalid && rsp_tready
//
// Each transaction settles one root bit per step in the shared subtract-and-shift
// unit, then checks the remainder. A new transaction is taken in the cycle the
// result is written. The result waits in an output register, so a stalled
// response holds only the finishing step. Synchronous reset clears the controller;
// no clearing pass is needed.
module perfect_square_root #(
   parameter int OPERAND_WIDTH = psqrt_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [psqrt_pkg::VALUE_WIDTH-1:0] req_tdata,  // [31:0] value
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [psqrt_pkg::ROOT_WIDTH-1:0]  rsp_tdata   // [15:0] root
);
   import psqrt_pkg::*;

   psqrt_cmd_type cmd;

   // Sequencing and handshakes.
   psqrt_controller #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // Root iteration and result register.
   psqrt_datapath #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_datapath (
      .clock (clock),
      .cmd   (cmd),
      .value (req_tdata),
      .root  (rsp_tdata)
   );

endmodule
